// File: hw/rtl/ltft_pkg.sv
`timescale 1ns / 1ps
package ltft_pkg;

  typedef struct packed {
    logic               func;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [9:0]         col_r;
    logic [9:0]         col_g;
    logic [9:0]         col_b;
    logic [15:0]        light_range;
  } in_item_t;

  typedef struct packed {
    logic               light_valid;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [9:0]         faded_r;
    logic [9:0]         faded_g;
    logic [9:0]         faded_b;
    logic [15:0]        out_range;
    logic [3:0]         live_count;
    logic               last;
  } out_item_t;

  localparam logic [0:0] FUNC_ADD  = 1'b0;
  localparam logic [0:0] FUNC_TICK = 1'b1;

  localparam logic [0:0] CFG_FADE_STEP = 1'b0;
  localparam logic [0:0] CFG_MATCH_DIST = 1'b1;

  localparam int unsigned DIST_W = 52;
  localparam logic [7:0] FADE_FULL = 8'd255;
  localparam logic [7:0] FADE_STEP_RST = 8'd31;
  localparam logic [DIST_W-1:0] MATCH_DIST_RST = 52'd921600;

  // datapath commands from the controller
  typedef struct packed {
    logic add;        // store input item in collect buffer
    logic clr_seen;
    logic cmp_ld;     // register operands for pend c vs trk i
    logic cmp_mul;    // register squares
    logic cmp_sum;    // register sum and compare
    logic hit_wr;     // write pend c into trk entry i (match)
    logic app_wr;     // append pend c at trk_count
    logic fade_upd;   // step fade of entry i, compact into n
    logic emit_ld;    // load output stage for entry i
    logic emit_mul;   // color times fade
    logic emit_out;   // form result
    logic empty_out;  // emit empty-tick result
    logic pend_clr;
    logic c_clr;
    logic c_inc;
    logic i_clr;
    logic i_inc;
    logic n_clr;
  } cmd_t;

  typedef struct packed {
    logic c_done;   // c >= pend_count
    logic i_done;   // i >= trk_count
    logic match;    // last compare result
    logic trk_full;
    logic trk_empty;
    logic out_last; // entry i is the final survivor
  } stat_t;

endpackage

// File: hw/rtl/ltft_datapath.sv
`timescale 1ns / 1ps
module ltft_datapath #(
  parameter int MAX_LIGHTS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ltft_pkg::cmd_t                 cmd,
  output ltft_pkg::stat_t                stat,
  input  ltft_pkg::in_item_t             in_item,
  input  logic [7:0]                     fade_inc,
  input  logic [ltft_pkg::DIST_W-1:0]    match_dist_sq,
  output ltft_pkg::out_item_t            res
);

  localparam int IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CW = $clog2(MAX_LIGHTS + 1);

  logic signed [23:0] pend_x [MAX_LIGHTS];
  logic signed [23:0] pend_y [MAX_LIGHTS];
  logic signed [23:0] pend_z [MAX_LIGHTS];
  logic [29:0]        pend_color [MAX_LIGHTS];
  logic [15:0]        pend_range [MAX_LIGHTS];
  logic [CW-1:0]      pend_count_r;
  logic               pend_wr;

  logic signed [23:0] trk_x [MAX_LIGHTS];
  logic signed [23:0] trk_y [MAX_LIGHTS];
  logic signed [23:0] trk_z [MAX_LIGHTS];
  logic [29:0]        trk_color [MAX_LIGHTS];
  logic [15:0]        trk_range [MAX_LIGHTS];
  logic [7:0]         trk_fade [MAX_LIGHTS];
  logic [MAX_LIGHTS-1:0] trk_seen_r;
  logic [CW-1:0]      trk_count_r;

  logic [CW-1:0] c_r, i_r, n_r;
  logic [IW-1:0] c_ix, i_ix, n_ix, tc_ix;

  logic [24:0] dx_r, dy_r, dz_r;
  logic [49:0] sx_r, sy_r, sz_r;
  logic        match_r;

  logic [7:0]  f_nxt;
  logic [7:0]  ef_r;
  logic [29:0] ecol_r;
  logic [17:0] pr_r, pg_r, pb_r;
  logic signed [23:0] ex_r, ey_r, ez_r;
  logic [15:0] erng_r;
  logic        elast_r;

  assign c_ix  = c_r[IW-1:0];
  assign i_ix  = i_r[IW-1:0];
  assign n_ix  = n_r[IW-1:0];
  assign tc_ix = trk_count_r[IW-1:0];

  // full buffer or zero range drops the add
  assign pend_wr = cmd.add && pend_count_r < CW'(MAX_LIGHTS) &&
                   in_item.light_range != 16'd0;

  function automatic logic [24:0] absdiff(input logic signed [23:0] a,
                                          input logic signed [23:0] b);
    logic signed [24:0] d;
    d = 25'(a) - 25'(b);
    return d[24] ? 25'(-d) : 25'(d);
  endfunction

  // x/255 for x<=1023*255: fold the base-256 digits twice, since 256 = 255 + 1
  function automatic logic [9:0] div255(input logic [17:0] x);
    logic [10:0] s1;
    logic [8:0]  s2;
    logic [10:0] q;
    s1 = 11'(x[17:8]) + 11'(x[7:0]);
    s2 = 9'(s1[10:8]) + 9'(s1[7:0]);
    q  = 11'(x[17:8]) + 11'(s1[10:8]) + ((s2 >= 9'd255) ? 11'd1 : 11'd0);
    return q[9:0];
  endfunction

  always_comb begin
    logic [8:0] up;
    up = 9'(trk_fade[i_ix]) + 9'(fade_inc);
    if (trk_seen_r[i_ix]) f_nxt = up[8] ? ltft_pkg::FADE_FULL : up[7:0];
    else f_nxt = (trk_fade[i_ix] < fade_inc) ? 8'd0 : trk_fade[i_ix] - fade_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_count_r <= '0;
      trk_count_r  <= '0;
      c_r <= '0;
      i_r <= '0;
      n_r <= '0;
    end else begin
      if (pend_wr)
        pend_count_r <= pend_count_r + 1'b1;
      if (cmd.pend_clr) pend_count_r <= '0;
      if (cmd.app_wr) trk_count_r <= trk_count_r + 1'b1;
      if (cmd.c_clr) c_r <= '0;
      else if (cmd.c_inc) c_r <= c_r + 1'b1;
      if (cmd.i_clr) i_r <= '0;
      else if (cmd.i_inc) i_r <= i_r + 1'b1;
      if (cmd.n_clr) n_r <= '0;
      else if (cmd.fade_upd && f_nxt != 8'd0) n_r <= n_r + 1'b1;
      if (cmd.fade_upd && i_r + 1'b1 >= trk_count_r)
        trk_count_r <= (f_nxt != 8'd0) ? n_r + 1'b1 : n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_wr) begin
      pend_x[pend_count_r[IW-1:0]]     <= in_item.pos_x;
      pend_y[pend_count_r[IW-1:0]]     <= in_item.pos_y;
      pend_z[pend_count_r[IW-1:0]]     <= in_item.pos_z;
      pend_color[pend_count_r[IW-1:0]] <= {in_item.col_b, in_item.col_g, in_item.col_r};
      pend_range[pend_count_r[IW-1:0]] <= in_item.light_range;
    end
    if (cmd.cmp_ld) begin
      dx_r <= absdiff(trk_x[i_ix], pend_x[c_ix]);
      dy_r <= absdiff(trk_y[i_ix], pend_y[c_ix]);
      dz_r <= absdiff(trk_z[i_ix], pend_z[c_ix]);
    end
    if (cmd.cmp_mul) begin
      sx_r <= dx_r * dx_r;
      sy_r <= dy_r * dy_r;
      sz_r <= dz_r * dz_r;
    end
    if (cmd.cmp_sum)
      match_r <= (52'(sx_r) + 52'(sy_r) + 52'(sz_r)) <= match_dist_sq;
    if (cmd.hit_wr || cmd.app_wr) begin
      trk_x[cmd.app_wr ? tc_ix : i_ix]     <= pend_x[c_ix];
      trk_y[cmd.app_wr ? tc_ix : i_ix]     <= pend_y[c_ix];
      trk_z[cmd.app_wr ? tc_ix : i_ix]     <= pend_z[c_ix];
      trk_color[cmd.app_wr ? tc_ix : i_ix] <= pend_color[c_ix];
      trk_range[cmd.app_wr ? tc_ix : i_ix] <= pend_range[c_ix];
      if (cmd.app_wr) trk_fade[tc_ix] <= 8'd0;
    end
    if (cmd.clr_seen) trk_seen_r <= '0;
    else if (cmd.hit_wr) trk_seen_r[i_ix] <= 1'b1;
    else if (cmd.app_wr) trk_seen_r[tc_ix] <= 1'b1;
    if (cmd.fade_upd) begin
      trk_fade[n_ix]  <= f_nxt;
      trk_x[n_ix]     <= trk_x[i_ix];
      trk_y[n_ix]     <= trk_y[i_ix];
      trk_z[n_ix]     <= trk_z[i_ix];
      trk_color[n_ix] <= trk_color[i_ix];
      trk_range[n_ix] <= trk_range[i_ix];
    end
    if (cmd.emit_ld) begin
      ef_r    <= trk_fade[i_ix];
      ecol_r  <= trk_color[i_ix];
      ex_r    <= trk_x[i_ix];
      ey_r    <= trk_y[i_ix];
      ez_r    <= trk_z[i_ix];
      erng_r  <= trk_range[i_ix];
      elast_r <= (i_r + 1'b1 >= trk_count_r);
    end
    if (cmd.emit_mul) begin
      pr_r <= ecol_r[9:0] * ef_r;
      pg_r <= ecol_r[19:10] * ef_r;
      pb_r <= ecol_r[29:20] * ef_r;
    end
    if (cmd.emit_out) begin
      res.light_valid <= 1'b1;
      res.out_x       <= ex_r;
      res.out_y       <= ey_r;
      res.out_z       <= ez_r;
      res.faded_r     <= div255(pr_r);
      res.faded_g     <= div255(pg_r);
      res.faded_b     <= div255(pb_r);
      res.out_range   <= erng_r;
      res.live_count  <= 4'(trk_count_r);
      res.last        <= elast_r;
    end else if (cmd.empty_out) begin
      res <= ltft_pkg::out_item_t'{last: 1'b1, default: '0};
    end
  end

  assign stat.c_done    = (c_r >= pend_count_r);
  assign stat.i_done    = (i_r >= trk_count_r);
  assign stat.match     = match_r;
  assign stat.trk_full  = (trk_count_r >= CW'(MAX_LIGHTS));
  assign stat.trk_empty = (trk_count_r == '0);
  assign stat.out_last  = elast_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    pend_count_r <= CW'(MAX_LIGHTS)) else $error("pend count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    trk_count_r <= CW'(MAX_LIGHTS)) else $error("trk count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.app_wr |-> !stat.trk_full) else $error("append into full table");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.hit_wr && cmd.app_wr)) else $error("hit and append together");

endmodule

// File: hw/rtl/ltft_ctrl.sv
`timescale 1ns / 1ps
module ltft_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  output logic                out_valid,
  input  logic                out_stall,
  input  ltft_pkg::stat_t     stat,
  output ltft_pkg::cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MERGE = 12'b000000000010,
    S_CMUL  = 12'b000000000100,
    S_CSUM  = 12'b000000001000,
    S_CDEC  = 12'b000000010000,
    S_CNEXT = 12'b000000100000,
    S_FADE  = 12'b000001000000,
    S_ELD   = 12'b000010000000,
    S_EMUL  = 12'b000100000000,
    S_EOUT  = 12'b001000000000,
    S_SEND  = 12'b010000000000,
    S_CHK   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == ltft_pkg::FUNC_ADD) cmd.add = 1'b1;
          else begin
            cmd.clr_seen = 1'b1;
            cmd.c_clr    = 1'b1;
            cmd.i_clr    = 1'b1;
            state_nxt    = S_MERGE;
          end
        end
      end
      // walk tracked entries for collected light c
      S_MERGE: begin
        if (stat.c_done) begin
          cmd.pend_clr = 1'b1;
          cmd.i_clr    = 1'b1;
          cmd.n_clr    = 1'b1;
          state_nxt    = S_FADE;
        end else if (stat.i_done) begin
          state_nxt = S_CNEXT;
        end else begin
          cmd.cmp_ld = 1'b1;
          state_nxt  = S_CMUL;
        end
      end
      S_CMUL: begin
        cmd.cmp_mul = 1'b1;
        state_nxt   = S_CSUM;
      end
      S_CSUM: begin
        cmd.cmp_sum = 1'b1;
        state_nxt   = S_CDEC;
      end
      S_CDEC: begin
        if (stat.match) begin
          cmd.hit_wr = 1'b1;
          cmd.c_inc  = 1'b1;
          cmd.i_clr  = 1'b1;
          state_nxt  = S_MERGE;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_MERGE;
        end
      end
      S_CNEXT: begin
        if (!stat.trk_full) cmd.app_wr = 1'b1;
        cmd.c_inc = 1'b1;
        cmd.i_clr = 1'b1;
        state_nxt = S_MERGE;
      end
      S_FADE: begin
        if (stat.i_done) begin
          cmd.i_clr = 1'b1;
          state_nxt = S_CHK;
        end else begin
          cmd.fade_upd = 1'b1;
          cmd.i_inc    = 1'b1;
        end
      end
      S_CHK: begin
        if (stat.trk_empty) begin
          cmd.empty_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_SEND;
        end else state_nxt = S_ELD;
      end
      S_ELD: begin
        cmd.emit_ld = 1'b1;
        state_nxt   = S_EMUL;
      end
      S_EMUL: begin
        cmd.emit_mul = 1'b1;
        state_nxt    = S_EOUT;
      end
      S_EOUT: begin
        cmd.emit_out  = 1'b1;
        cmd.i_inc     = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_SEND;
      end
      S_SEND: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = (stat.out_last || stat.trk_empty) ? S_IDLE : S_ELD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_SEND) else $error("result outside send");
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid_r) else $error("accepting with result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");

endmodule

// File: hw/rtl/light_track_fade_table.sv
`timescale 1ns / 1ps
// light tracking table with per-frame fade
// input channel: in_valid/in_stall with in_item. func add stores a light in
// the collect buffer and gives no result; an add is dropped when the buffer
// is full or the range is zero. func tick merges the collected lights into
// the tracked table, steps fades, compacts out dead entries and emits one
// result per survivor (or one empty result), last set on the final one.
// tick sequence: accept; per collected light, distance compares (load,
// square, sum, decide) on one shared compare unit, stopping at the first
// match, else an append if the table has room; leaving the merge; a fade
// pass with compaction; a check; then load, multiply and output per result.
// input is stalled for the whole tick.
// result channel: out_valid/out_stall, held stable while stalled; the tick
// sequencer waits on each result transfer.
// config channel: cfg_valid/cfg_ready with cfg_index, cfg_data; always ready.
// reset (rst_n low, synchronous): both tables empty, fade step 31,
// match distance 921600.
module light_track_fade_table #(
  parameter int MAX_LIGHTS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ltft_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ltft_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [ltft_pkg::DIST_W-1:0] cfg_data
);

  logic [7:0]                  fade_inc_r;
  logic [ltft_pkg::DIST_W-1:0] match_dist_r;
  ltft_pkg::cmd_t  cmd;
  ltft_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_inc_r   <= ltft_pkg::FADE_STEP_RST;
      match_dist_r <= ltft_pkg::MATCH_DIST_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ltft_pkg::CFG_FADE_STEP:  fade_inc_r   <= cfg_data[7:0];
        ltft_pkg::CFG_MATCH_DIST: match_dist_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ltft_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_func(in_item.func),
    .out_valid, .out_stall, .stat, .cmd
  );

  ltft_datapath #(.MAX_LIGHTS(MAX_LIGHTS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_item,
    .fade_inc(fade_inc_r), .match_dist_sq(match_dist_r), .res(out_item)
  );

endmodule

// File: test/tb_light_track_fade_table.sv
`timescale 1ns / 1ps
module tb_light_track_fade_table;

  localparam int NL = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ltft_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ltft_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [ltft_pkg::DIST_W-1:0] cfg_data = '0;

  light_track_fade_table #(.MAX_LIGHTS(NL)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [7:0] fade_inc_q;
  logic [ltft_pkg::DIST_W-1:0] match_dist_q;
  ltft_pkg::in_item_t collected [NL];
  int collected_cnt;
  ltft_pkg::in_item_t tracked [NL];
  int unsigned track_fade [NL];
  bit track_seen [NL];
  int track_cnt;

  ltft_pkg::out_item_t expected_lights[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  function automatic longint unsigned sq_delta(logic signed [23:0] a, logic signed [23:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d * d);
  endfunction

  function automatic void predict_item(ltft_pkg::in_item_t it);
    int hit;
    int n;
    int unsigned f;
    longint unsigned dsq;
    ltft_pkg::out_item_t o;
    if (it.func == ltft_pkg::FUNC_ADD) begin
      if (collected_cnt < NL && it.light_range != 0) begin
        collected[collected_cnt] = it;
        collected_cnt++;
      end
      return;
    end
    for (int i = 0; i < track_cnt; i++) track_seen[i] = 1'b0;
    for (int c = 0; c < collected_cnt; c++) begin
      hit = -1;
      for (int i = 0; i < track_cnt; i++) begin
        dsq = sq_delta(tracked[i].pos_x, collected[c].pos_x) +
              sq_delta(tracked[i].pos_y, collected[c].pos_y) +
              sq_delta(tracked[i].pos_z, collected[c].pos_z);
        if (dsq <= match_dist_q) begin
          hit = i;
          break;
        end
      end
      if (hit < 0 && track_cnt < NL) begin
        hit = track_cnt;
        track_cnt++;
        track_fade[hit] = 0;
      end
      if (hit >= 0) begin
        tracked[hit] = collected[c];
        track_seen[hit] = 1'b1;
      end
    end
    collected_cnt = 0;
    n = 0;
    for (int i = 0; i < track_cnt; i++) begin
      f = track_fade[i];
      if (track_seen[i]) f = (f + fade_inc_q > 255) ? 255 : f + fade_inc_q;
      else f = (f < fade_inc_q) ? 0 : f - fade_inc_q;
      track_fade[i] = f;
      if (f > 0) begin
        tracked[n] = tracked[i];
        track_fade[n] = f;
        track_seen[n] = track_seen[i];
        n++;
      end
    end
    track_cnt = n;
    if (n == 0) begin
      o = '0;
      o.last = 1'b1;
      expected_lights.push_back(o);
      return;
    end
    for (int i = 0; i < n; i++) begin
      o.light_valid = 1'b1;
      o.out_x = tracked[i].pos_x;
      o.out_y = tracked[i].pos_y;
      o.out_z = tracked[i].pos_z;
      o.faded_r = 10'((tracked[i].col_r * track_fade[i]) / 255);
      o.faded_g = 10'((tracked[i].col_g * track_fade[i]) / 255);
      o.faded_b = 10'((tracked[i].col_b * track_fade[i]) / 255);
      o.out_range = tracked[i].light_range;
      o.live_count = 4'(n);
      o.last = (i == n - 1);
      expected_lights.push_back(o);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    ltft_pkg::out_item_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lights.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
      end else begin
        exp_o = expected_lights.pop_front();
        if (out_item !== exp_o) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, exp_o, out_item);
          if (out_item.light_valid !== exp_o.light_valid)
            $display("  light_valid expected %b actual %b", exp_o.light_valid, out_item.light_valid);
          if (out_item.out_x !== exp_o.out_x || out_item.out_y !== exp_o.out_y ||
              out_item.out_z !== exp_o.out_z)
            $display("  position expected %0d %0d %0d actual %0d %0d %0d",
                     exp_o.out_x, exp_o.out_y, exp_o.out_z,
                     out_item.out_x, out_item.out_y, out_item.out_z);
          if (out_item.faded_r !== exp_o.faded_r || out_item.faded_g !== exp_o.faded_g ||
              out_item.faded_b !== exp_o.faded_b)
            $display("  color expected %0d %0d %0d actual %0d %0d %0d",
                     exp_o.faded_r, exp_o.faded_g, exp_o.faded_b,
                     out_item.faded_r, out_item.faded_g, out_item.faded_b);
          if (out_item.out_range !== exp_o.out_range)
            $display("  range expected %0d actual %0d", exp_o.out_range, out_item.out_range);
          if (out_item.live_count !== exp_o.live_count || out_item.last !== exp_o.last)
            $display("  count/last expected %0d/%b actual %0d/%b", exp_o.live_count,
                     exp_o.last, out_item.live_count, out_item.last);
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on quiet cycles
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // valid stays up after a transfer until the next send or drain takes it over
  task automatic send_light(ltft_pkg::in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
  endtask

  function automatic ltft_pkg::in_item_t make_add(int x, int y, int z, int r, int g, int b,
                                                  int rng);
    ltft_pkg::in_item_t it;
    it.func = ltft_pkg::FUNC_ADD;
    it.pos_x = 24'(x);
    it.pos_y = 24'(y);
    it.pos_z = 24'(z);
    it.col_r = 10'(r);
    it.col_g = 10'(g);
    it.col_b = 10'(b);
    it.light_range = 16'(rng);
    return it;
  endfunction

  function automatic ltft_pkg::in_item_t make_tick();
    logic [127:0] raw;
    ltft_pkg::in_item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(ltft_pkg::in_item_t)-1:0];
    it.func = ltft_pkg::FUNC_TICK;
    return it;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_lights.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [ltft_pkg::DIST_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == ltft_pkg::CFG_FADE_STEP) fade_inc_q = val[7:0];
    else match_dist_q = val;
  endtask

  task automatic test_directed();
    send_light(make_tick());
    send_light(make_add(8388607, -8388608, 0, 1023, 0, 512, 65535));
    send_light(make_add(100, 100, 100, 256, 256, 256, 0));
    send_light(make_add(-8388608, 8388607, -1, 0, 1023, 1, 1));
    send_light(make_tick());
    send_light(make_add(8388600, -8388600, 5, 1023, 1023, 1023, 7));
    send_light(make_tick());
    for (int k = 0; k < 10; k++)
      send_light(make_add(k * 100000, -k * 50000, k, k * 90, 1023 - k, k, 100 + k));
    send_light(make_tick());
    send_light(make_tick());
  endtask

  task automatic test_config_sweep();
    write_reg(ltft_pkg::CFG_FADE_STEP, 52'd255);
    write_reg(ltft_pkg::CFG_MATCH_DIST, 52'd0);
    send_light(make_add(0, 0, 0, 1023, 1023, 1023, 9));
    send_light(make_tick());
    send_light(make_add(0, 0, 0, 500, 400, 300, 10));
    send_light(make_add(1, 0, 0, 500, 400, 300, 11));
    send_light(make_tick());
    send_light(make_tick());
    write_reg(ltft_pkg::CFG_FADE_STEP, 52'd1);
    write_reg(ltft_pkg::CFG_MATCH_DIST, {ltft_pkg::DIST_W{1'b1}});
    send_light(make_add(8388607, 8388607, 8388607, 3, 4, 5, 1));
    send_light(make_add(-8388608, -8388608, -8388608, 6, 7, 8, 2));
    send_light(make_tick());
    send_light(make_tick());
    write_reg(ltft_pkg::CFG_FADE_STEP, 52'd0);
    send_light(make_add(0, 0, 0, 100, 100, 100, 3));
    send_light(make_tick());
  endtask

  task automatic test_random(int items);
    int cluster;
    int cnt;
    cnt = 0;
    while (cnt < items) begin
      if ($urandom_range(9) == 0) begin
        send_light(make_add($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom_range(1) ? 0 : $urandom));
      end else begin
        cluster = $urandom_range(3);
        send_light(make_add(cluster * 2000 + $urandom_range(600) - 300,
                            $urandom_range(600) - 300, $urandom_range(31) - 16,
                            $urandom_range(1023), $urandom_range(1023),
                            $urandom_range(1023), $urandom_range(65535, 1)));
      end
      cnt++;
      if ($urandom_range(4) == 0) begin
        send_light(make_tick());
        cnt++;
      end
    end
    send_light(make_tick());
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int k = 0; k < 3; k++) begin
          send_light(make_add(k * 5000, 0, 0, 300, 300, 300, 50));
          send_light(make_tick());
        end
      end
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  initial begin
    fade_inc_q = ltft_pkg::FADE_STEP_RST;
    match_dist_q = ltft_pkg::MATCH_DIST_RST;
    collected_cnt = 0;
    track_cnt = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_sweep();
    write_reg(ltft_pkg::CFG_FADE_STEP, 52'd64);
    write_reg(ltft_pkg::CFG_MATCH_DIST, 52'd90000);
    test_random(50);
    send_idle_pct = 75;
    write_reg(ltft_pkg::CFG_FADE_STEP, 52'(ltft_pkg::FADE_STEP_RST));
    test_random(45);
    send_idle_pct = 0;
    recv_stall_pct = 75;
    write_reg(ltft_pkg::CFG_MATCH_DIST, ltft_pkg::MATCH_DIST_RST);
    test_random(45);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    write_reg(ltft_pkg::CFG_FADE_STEP, 52'd200);
    test_random(45);
    recv_stall_pct = 0;
    send_idle_pct = 0;
    test_backpressure();

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
